/* sv/aol_pkg.sv */
`default_nettype none

package aol_pkg;

    // fixed field widths of the item and result beats
    localparam int KIND_W   = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_POP_FRONT  = 3'd1,
        K_PUSH_BACK  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_INSERT     = 3'd4,
        K_REMOVE     = 3'd5,
        K_READ       = 3'd6
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // source of the entry memory write data
    typedef enum logic [1:0] {
        WS_INPUT = 2'd0,
        WS_HELD  = 2'd1,
        WS_SHIFT = 2'd2
    } t_wr_src;

    // controller to datapath command group
    typedef struct packed {
        logic    wr_en;
        t_wr_src wr_src;
        logic    rd_en;
        logic    val_load;
        logic    out_load;
        logic    out_rd_sel;
        t_status out_status;
        logic    out_empty;
        logic    out_full;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* sv/aol_dp.sv */
`default_nettype none

module aol_dp
    import aol_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire t_dp_cmd                     i_cmd,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_wr_addr,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_rd_addr,
    input  wire logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  wire logic [VALUE_W-1:0]          i_value,
    output logic      [STATUS_W-1:0]         o_status,
    output logic      [VALUE_W-1:0]          o_read_value,
    output logic      [COUNT_W-1:0]          o_count,
    output logic                             o_is_empty,
    output logic                             o_is_full
);

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [DATA_WIDTH-1:0] r_held;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [STATUS_W-1:0]   r_status;
    logic [VALUE_W-1:0]    r_read_value;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_is_empty;
    logic                  r_is_full;

    // write data select
    always_comb begin
        case (i_cmd.wr_src)
            WS_INPUT: wr_data = DATA_WIDTH'(i_value);
            WS_HELD:  wr_data = r_held;
            WS_SHIFT: wr_data = r_rd_data;
            default:  wr_data = r_rd_data;
        endcase
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // held value for inserts
    always_ff @(posedge i_clk) begin
        if (i_cmd.val_load) begin
            r_held <= DATA_WIDTH'(i_value);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status     <= i_cmd.out_status;
            r_read_value <= i_cmd.out_rd_sel ? VALUE_W'(r_rd_data) : '0;
            r_count      <= COUNT_W'(i_count);
            r_is_empty   <= i_cmd.out_empty;
            r_is_full    <= i_cmd.out_full;
        end
    end

    assign o_status     = r_status;
    assign o_read_value = r_read_value;
    assign o_count      = r_count;
    assign o_is_empty   = r_is_empty;
    assign o_is_full    = r_is_full;

endmodule

`default_nettype wire

/* sv/aol_ctrl.sv */
`default_nettype none

module aol_ctrl
    import aol_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [KIND_W-1:0]             i_kind,
    input  wire logic [POS_W-1:0]              i_position,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output t_dp_cmd                            o_cmd,
    output logic      [$clog2(CAPACITY)-1:0]   o_wr_addr,
    output logic      [$clog2(CAPACITY)-1:0]   o_rd_addr,
    output logic      [$clog2(CAPACITY+1)-1:0] o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_DN,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_ptr, n_ptr;
    t_status       r_status, n_status;
    logic          r_rd_sel, n_rd_sel;
    logic          r_out_valid, n_out_valid;

    t_dp_cmd       cmd;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [AW-1:0] pos_idx;
    logic [AW-1:0] ins_idx;
    logic [AW-1:0] rem_idx;
    logic          is_full;
    logic          is_empty;
    logic          pos_nz;
    logic          ins_ok;
    logic          pos_ok;
    logic          out_free;

    // position checks against the current count
    always_comb begin
        pos_ext  = PW'(i_position);
        cnt_ext  = PW'(r_count);
        pos_nz   = (i_position != '0);
        ins_ok   = pos_nz && (pos_ext <= cnt_ext + 1'b1);
        pos_ok   = pos_nz && (pos_ext <= cnt_ext);
        pos_idx  = AW'(pos_ext - 1'b1);
        is_full  = (r_count == CW'(CAPACITY));
        is_empty = (r_count == '0);
        ins_idx  = (t_kind'(i_kind) == K_INSERT) ? pos_idx : '0;
        rem_idx  = (t_kind'(i_kind) == K_REMOVE) ? pos_idx : '0;
        out_free = !r_out_valid || !i_out_stall;
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_status    = r_status;
        n_rd_sel    = r_rd_sel;
        n_out_valid = r_out_valid;
        cmd         = '0;
        wr_addr     = '0;
        rd_addr     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.val_load = 1'b1;
                    n_status     = ST_OK;
                    n_rd_sel     = 1'b0;
                    n_state      = S_DONE;
                    case (t_kind'(i_kind))
                        K_PUSH_FRONT, K_INSERT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else if (t_kind'(i_kind) == K_INSERT && !ins_ok) begin
                                n_status = ST_BADPOS;
                            end else if (r_count == CW'(ins_idx)) begin
                                // append at the tail, no shift
                                cmd.wr_en  = 1'b1;
                                cmd.wr_src = WS_INPUT;
                                wr_addr    = ins_idx;
                                n_count    = r_count + 1'b1;
                            end else begin
                                // open a gap, walking down from the tail
                                n_idx      = ins_idx;
                                cmd.rd_en  = 1'b1;
                                rd_addr    = AW'(r_count - 1'b1);
                                n_ptr      = AW'(r_count - 1'b1);
                                n_state    = S_UP;
                            end
                        end
                        K_POP_FRONT, K_REMOVE: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else if (t_kind'(i_kind) == K_REMOVE && !pos_ok) begin
                                n_status = ST_BADPOS;
                            end else if (CW'(rem_idx) == r_count - 1'b1) begin
                                // last entry, nothing to move
                                n_count = r_count - 1'b1;
                            end else begin
                                // close the gap, walking up from it
                                cmd.rd_en = 1'b1;
                                rd_addr   = rem_idx + 1'b1;
                                n_ptr     = rem_idx + 1'b1;
                                n_state   = S_DN;
                            end
                        end
                        K_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_src = WS_INPUT;
                                wr_addr    = AW'(r_count);
                                n_count    = r_count + 1'b1;
                            end
                        end
                        K_POP_BACK: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        K_READ: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else if (!pos_ok) begin
                                n_status = ST_BADPOS;
                            end else begin
                                cmd.rd_en = 1'b1;
                                rd_addr   = pos_idx;
                                n_rd_sel  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UP: begin
                // move the entry read last cycle one slot up
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WS_SHIFT;
                wr_addr    = r_ptr + 1'b1;
                if (r_ptr == r_idx) begin
                    n_state = S_PUT;
                end else begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = r_ptr - 1'b1;
                    n_ptr     = r_ptr - 1'b1;
                end
            end
            S_PUT: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WS_HELD;
                wr_addr    = r_idx;
                n_count    = r_count + 1'b1;
                n_state    = S_DONE;
            end
            S_DN: begin
                // move the entry read last cycle one slot down
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WS_SHIFT;
                wr_addr    = r_ptr - 1'b1;
                if (CW'(r_ptr) == r_count - 1'b1) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = r_ptr + 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = r_status;
                    cmd.out_rd_sel = r_rd_sel;
                    cmd.out_empty  = is_empty;
                    cmd.out_full   = is_full;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_rd_sel    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_rd_sel    <= n_rd_sel;
        end
        r_idx <= n_idx;
        r_ptr <= n_ptr;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign o_wr_addr   = wr_addr;
    assign o_rd_addr   = rd_addr;
    assign o_count     = r_count;

endmodule

`default_nettype wire

/* sv/array_ordered_list_core.sv */
`default_nettype none

// channel   direction  handshake                 payload
// item      in         i_in_valid / o_in_stall    i_kind, i_position, i_value
// result    out        o_out_valid / i_out_stall  o_status, o_read_value, o_count,
//                                                 o_is_empty, o_is_full
//
// one item at a time; a push back, pop back, read, append or refused item goes from idle straight to done
// an insert at 0-based slot k < count moves count-k entries up, a remove moves count-k-1 entries down:
// entries move one per cycle through the single write port of the entry memory
// reset clears the state, count and result valid; memory contents are not cleared and need no pass
// a stalled result holds; the next item is taken and worked while it waits

module array_ordered_list_core
    import aol_pkg::*;
#(
    parameter int CAPACITY   = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic [VALUE_W-1:0]  i_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [VALUE_W-1:0]  o_read_value,
    output logic      [COUNT_W-1:0]  o_count,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_dp_cmd       dp_cmd;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] count;

    // controller
    aol_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .o_count     (count)
    );

    // datapath
    aol_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (dp_cmd),
        .i_wr_addr    (wr_addr),
        .i_rd_addr    (rd_addr),
        .i_count      (count),
        .i_value      (i_value),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    // a shift never reads the slot it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.wr_en && dp_cmd.rd_en) |-> (wr_addr != rd_addr))
        else $error("memory read and write at the same slot");

    // a taken item keeps the input side busy in the cycle after it
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again without a busy cycle");

    // a new result never overwrites one still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result loaded over a stalled beat");

    // empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_count == '0 && !o_is_full))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

/* bench/array_ordered_list_core_checker.sv */
`timescale 1ns / 1ps

module array_ordered_list_core_checker
    import aol_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic [VALUE_W-1:0]  i_value,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire logic [STATUS_W-1:0] i_status,
    input  wire logic [VALUE_W-1:0]  i_read_value,
    input  wire logic [COUNT_W-1:0]  i_count,
    input  wire logic                i_is_empty,
    input  wire logic                i_is_full,
    output int                       o_fail_count,
    output int                       o_pending
);

    // what one result beat should carry
    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   read_value;
        logic [COUNT_W-1:0]   count;
        logic                 is_empty;
        logic                 is_full;
    } t_list_outcome;

    // shadow copy of the list
    logic [VALUE_W-1:0] shelf [CAPACITY];
    int                 held;

    t_list_outcome outcomes_due [$];
    t_list_outcome want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held         = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: list result error: %s", $time, msg);
        o_fail_count++;
    endtask

    // shift entries at and after slot up by one and store the new entry
    function automatic void place_entry(input int slot, input logic [VALUE_W-1:0] val);
        for (int i = held; i > slot; i--) begin
            shelf[i] = shelf[i-1];
        end
        shelf[slot] = val;
        held++;
    endfunction

    // shift entries after slot down by one
    function automatic void drop_entry(input int slot);
        for (int i = slot; i + 1 < held; i++) begin
            shelf[i] = shelf[i+1];
        end
        held--;
    endfunction

    // apply one operation to the shadow list and return its result beat
    function automatic t_list_outcome apply_list_op(
        input logic [KIND_W-1:0]  kind,
        input logic [POS_W-1:0]   pos,
        input logic [VALUE_W-1:0] val
    );
        t_list_outcome res;
        int            p;
        p              = int'(pos);
        res.status     = ST_OK;
        res.read_value = '0;
        case (kind)
            K_PUSH_FRONT: begin
                if (held >= CAPACITY) res.status = ST_FULL;
                else place_entry(0, val);
            end
            K_POP_FRONT: begin
                if (held == 0) res.status = ST_EMPTY;
                else drop_entry(0);
            end
            K_PUSH_BACK: begin
                if (held >= CAPACITY) res.status = ST_FULL;
                else place_entry(held, val);
            end
            K_POP_BACK: begin
                if (held == 0) res.status = ST_EMPTY;
                else held--;
            end
            K_INSERT: begin
                // full is checked ahead of the position
                if (held >= CAPACITY) res.status = ST_FULL;
                else if (p == 0 || p > held + 1) res.status = ST_BADPOS;
                else place_entry(p - 1, val);
            end
            K_REMOVE: begin
                if (held == 0) res.status = ST_EMPTY;
                else if (p == 0 || p > held) res.status = ST_BADPOS;
                else drop_entry(p - 1);
            end
            K_READ: begin
                if (held == 0) res.status = ST_EMPTY;
                else if (p == 0 || p > held) res.status = ST_BADPOS;
                else res.read_value = shelf[p-1];
            end
            default: begin
                // unused code: no change, status ok
            end
        endcase
        res.count    = COUNT_W'(held);
        res.is_empty = (held == 0);
        res.is_full  = (held >= CAPACITY);
        return res;
    endfunction

    // result beats are checked before item beats of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            outcomes_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outcomes_due.size() == 0) begin
                    report_mismatch($sformatf(
                        "result beat with no item waiting (status %0d count %0d)",
                        i_status, i_count));
                end else begin
                    want = outcomes_due[0];
                    outcomes_due.delete(0);
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    if (i_read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  i_read_value, want.read_value));
                    if (i_count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  i_count, want.count));
                    if (i_is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %b, expected %b",
                                                  i_is_empty, want.is_empty));
                    if (i_is_full !== want.is_full)
                        report_mismatch($sformatf("is_full %b, expected %b",
                                                  i_is_full, want.is_full));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                outcomes_due.insert(outcomes_due.size(),
                                    apply_list_op(i_kind, i_position, i_value));
            end
        end
        o_pending = outcomes_due.size();
    end

endmodule

/* bench/array_ordered_list_core_tb.sv */
`timescale 1ns / 1ps

module array_ordered_list_core_tb;
    import aol_pkg::*;

    localparam int LIST_DEPTH   = 128;
    localparam int RANDOM_ITEMS = 1826;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE       = 200;

    // the one kind code with no operation behind it
    localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;

    // shape of the random traffic
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_CHURN
    } t_mix;

    logic                i_clk;
    logic                rst_n     = 1'b0;
    logic                op_valid  = 1'b0;
    logic                op_stall;
    logic [KIND_W-1:0]   op_kind   = '0;
    logic [POS_W-1:0]    op_pos    = '0;
    logic [VALUE_W-1:0]  op_value  = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [STATUS_W-1:0] res_status;
    logic [VALUE_W-1:0]  res_read_value;
    logic [COUNT_W-1:0]  res_count;
    logic                res_empty;
    logic                res_full;
    int                  fail_count;
    int                  pending;

    int                  list_len  = 0;
    int                  cycles    = 0;
    int                  stall_span = 0;
    int                  stall_pct  = 0;

    array_ordered_list_core #(
        .CAPACITY   (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (op_valid),
        .o_in_stall   (op_stall),
        .i_kind       (op_kind),
        .i_position   (op_pos),
        .i_value      (op_value),
        .o_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .o_status     (res_status),
        .o_read_value (res_read_value),
        .o_count      (res_count),
        .o_is_empty   (res_empty),
        .o_is_full    (res_full)
    );

    array_ordered_list_core_checker #(
        .CAPACITY (LIST_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (op_valid),
        .i_in_stall   (op_stall),
        .i_kind       (op_kind),
        .i_position   (op_pos),
        .i_value      (op_value),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_status     (res_status),
        .i_read_value (res_read_value),
        .i_count      (res_count),
        .i_is_empty   (res_empty),
        .i_is_full    (res_full),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side stalls in segments of varying density
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_span <= $urandom_range(10, 150);
            case ($urandom_range(3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
            res_stall <= 1'b0;
        end else begin
            stall_span <= stall_span - 1;
            res_stall  <= ($urandom_range(99) < stall_pct);
        end
    end

    // drive one item beat and hold it until taken; track the entry count
    task automatic offer_op(
        input logic [KIND_W-1:0]  kind,
        input logic [POS_W-1:0]   pos,
        input logic [VALUE_W-1:0] val
    );
        @(negedge i_clk);
        op_valid <= 1'b1;
        op_kind  <= kind;
        op_pos   <= pos;
        op_value <= val;
        @(posedge i_clk);
        while (op_stall) @(posedge i_clk);
        case (kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
                if (list_len < LIST_DEPTH) list_len++;
            end
            K_POP_FRONT, K_POP_BACK: begin
                if (list_len > 0) list_len--;
            end
            K_INSERT: begin
                if (list_len < LIST_DEPTH && pos != 0 && pos <= list_len + 1) list_len++;
            end
            K_REMOVE: begin
                if (pos != 0 && pos <= list_len) list_len--;
            end
            default: begin
            end
        endcase
    endtask

    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            op_valid <= 1'b0;
        end
    endtask

    // stop sending until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        op_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int                 sent;
        int                 burst_left;
        int                 r;
        int                 grow_pct;
        int                 shrink_pct;
        t_mix               mix;
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;

        sent       = 0;
        burst_left = 0;
        mix        = MIX_FILL;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // directed: empty list cases
        offer_op(K_POP_FRONT, 8'd0, 32'h0);
        offer_op(K_POP_BACK, 8'd1, 32'h0);
        offer_op(K_REMOVE, 8'd1, 32'h0);
        offer_op(K_READ, 8'd0, 32'h0);
        offer_op(K_INSERT, 8'd0, 32'h1234_5678);
        offer_op(K_INSERT, 8'd2, 32'h1234_5678);
        // directed: build a short list with extreme values
        offer_op(K_INSERT, 8'd1, 32'hFFFF_FFFF);
        offer_op(K_PUSH_FRONT, 8'd0, 32'h0000_0000);
        offer_op(K_PUSH_BACK, 8'd255, 32'h8000_0001);
        offer_op(K_INSERT, 8'd4, 32'hA5A5_A5A5);
        offer_op(K_INSERT, 8'd2, 32'h5A5A_5A5A);
        // directed: reads at and past both ends
        offer_op(K_READ, 8'd0, 32'h0);
        offer_op(K_READ, 8'd1, 32'h0);
        offer_op(K_READ, 8'd5, 32'h0);
        offer_op(K_READ, 8'd6, 32'h0);
        offer_op(K_READ, 8'd255, 32'h0);
        offer_op(K_UNUSED, 8'd3, 32'hFFFF_FFFF);
        // directed: removes, bad positions and pops
        offer_op(K_REMOVE, 8'd0, 32'h0);
        offer_op(K_REMOVE, 8'd6, 32'h0);
        offer_op(K_REMOVE, 8'd3, 32'h0);
        offer_op(K_INSERT, 8'd255, 32'hDEAD_BEEF);
        offer_op(K_POP_FRONT, 8'd0, 32'h0);
        offer_op(K_POP_BACK, 8'd0, 32'h0);
        offer_op(K_READ, 8'd1, 32'h0);

        wait_drained();

        // random: fill to full, drain to empty, and mixed stretches
        while (sent < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                if ($urandom_range(4) == 0) begin
                    burst_left = $urandom_range(20, 80);
                end else begin
                    hold_off($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 16);
                end
            end

            case (mix)
                MIX_FILL: begin
                    grow_pct   = 65;
                    shrink_pct = 15;
                end
                MIX_DRAIN: begin
                    grow_pct   = 20;
                    shrink_pct = 60;
                end
                default: begin
                    grow_pct   = 40;
                    shrink_pct = 40;
                end
            endcase

            r = $urandom_range(99);
            if (r < grow_pct) begin
                case ($urandom_range(2))
                    0: kind = K_PUSH_FRONT;
                    1: kind = K_PUSH_BACK;
                    default: kind = K_INSERT;
                endcase
            end else if (r < grow_pct + shrink_pct) begin
                case ($urandom_range(2))
                    0: kind = K_POP_FRONT;
                    1: kind = K_POP_BACK;
                    default: kind = K_REMOVE;
                endcase
            end else if (r < 97) begin
                kind = K_READ;
            end else begin
                kind = K_UNUSED;
            end

            // mostly in range, some zero, just past the end, or anywhere
            r = $urandom_range(99);
            if (r < 80) pos = POS_W'($urandom_range(1, list_len + 1));
            else if (r < 87) pos = '0;
            else if (r < 94) pos = POS_W'(list_len + 1 + int'($urandom_range(1)));
            else pos = POS_W'($urandom_range(255));

            case ($urandom_range(9))
                0: val = '0;
                1: val = '1;
                default: val = $urandom;
            endcase

            offer_op(kind, pos, val);
            sent++;
            burst_left--;

            if (sent % 450 == 0) begin
                wait_drained();
                burst_left = 0;
            end

            case (mix)
                MIX_FILL: begin
                    if (list_len == LIST_DEPTH && $urandom_range(9) == 0) mix = MIX_DRAIN;
                end
                MIX_DRAIN: begin
                    if (list_len == 0 && $urandom_range(4) == 0) begin
                        mix = ($urandom_range(2) == 0) ? MIX_CHURN : MIX_FILL;
                    end
                end
                default: begin
                    if ($urandom_range(149) == 0) mix = MIX_FILL;
                end
            endcase
        end

        wait_drained();
        repeat (SETTLE) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
